@@ rtl/core/chp_pkg.sv @@
// ----------------------------------------------------------------------------
// chp_pkg - compass heading pipeline shared definitions
// Word formats, CORDIC sizing and the arctangent table for the stage cells.
// ----------------------------------------------------------------------------
package chp_pkg;

	localparam int CORDIC_STAGES     = 16;
	localparam int HEADING_FRAC_BITS = 7;

	localparam int ATAN_TABLE_LEN = 24;
	localparam int RUN_STAGES     = (CORDIC_STAGES < ATAN_TABLE_LEN) ?
		CORDIC_STAGES : ATAN_TABLE_LEN;
	localparam int STAGE_IDX_W    = $clog2(ATAN_TABLE_LEN);

	localparam int FIELD_W        = 16;
	localparam int HEADING_W      = 16;
	localparam int VEC_SCALE_BITS = 8;
	// field * 256, negated, grown by the CORDIC gain, plus sign
	localparam int VEC_W          = FIELD_W + VEC_SCALE_BITS + 3;

	// angle in 2^-20 degree, spans about -100 to +280 degrees
	localparam int ANGLE_BITS  = 20;
	localparam int ANG_W       = 30;
	localparam int ROUND_SHIFT = ANGLE_BITS - HEADING_FRAC_BITS;
	localparam int H_W         = ANG_W - ROUND_SHIFT;

	localparam logic signed [ANG_W-1:0] HALF_TURN_ANG = ANG_W'(180 <<< ANGLE_BITS);
	localparam logic signed [ANG_W-1:0] FULL_TURN_ANG = ANG_W'(360 <<< ANGLE_BITS);
	localparam logic signed [ANG_W-1:0] ROUND_HALF    = ANG_W'(1 <<< (ROUND_SHIFT - 1));
	localparam logic [H_W-1:0]          TURN_HEADING  = H_W'(360 <<< HEADING_FRAC_BITS);

	// atan(2^-i) in degrees, 2^-20 degree units, rounded to nearest
	localparam logic signed [ANG_W-1:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
		30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
		30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
		30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
		30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
		30'sd917,      30'sd458,      30'sd229,      30'sd115,
		30'sd57,       30'sd29,       30'sd14,       30'sd7
	};

	// one word moving down the cell chain
	typedef struct packed {
		logic                      ok;
		logic                      zero_vec;
		logic signed [FIELD_W-1:0] x_field;
		logic signed [FIELD_W-1:0] y_field;
		logic signed [FIELD_W-1:0] z_field;
		logic signed [VEC_W-1:0]   vx;
		logic signed [VEC_W-1:0]   vy;
		logic signed [ANG_W-1:0]   ang;
	} chp_word_t;

endpackage

@@ rtl/core/chp_input_stage.sv @@
// ----------------------------------------------------------------------------
// chp_input_stage - byte assembly and quadrant fold
// Builds the signed fields, scales the vector and folds X < 0 by 180 degrees.
// ----------------------------------------------------------------------------
module chp_input_stage
	import chp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [7:0]  byte_0,
	input  logic [7:0]  byte_1,
	input  logic [7:0]  byte_2,
	input  logic [7:0]  byte_3,
	input  logic [7:0]  byte_4,
	input  logic [7:0]  byte_5,
	input  logic        read_complete,
	output logic        out_valid,
	output chp_word_t   out_word
);

	logic signed [FIELD_W-1:0] xf, yf, zf;
	logic signed [VEC_W-1:0]   vx_scaled, vy_scaled;
	chp_word_t                 word_d;
	logic                      valid_s1;
	chp_word_t                 word_s1;

	always_comb begin
		xf = read_complete ? $signed({byte_0, byte_1}) : '0;
		yf = read_complete ? $signed({byte_2, byte_3}) : '0;
		zf = read_complete ? $signed({byte_4, byte_5}) : '0;
		vx_scaled = VEC_W'($signed({xf, {VEC_SCALE_BITS{1'b0}}}));
		vy_scaled = VEC_W'($signed({yf, {VEC_SCALE_BITS{1'b0}}}));

		word_d.ok       = read_complete;
		word_d.zero_vec = (xf == '0) && (yf == '0);
		word_d.x_field  = xf;
		word_d.y_field  = yf;
		word_d.z_field  = zf;
		// fold the left half plane onto the right one
		if (xf < 0) begin
			word_d.vx  = -vx_scaled;
			word_d.vy  = -vy_scaled;
			word_d.ang = HALF_TURN_ANG;
		end else begin
			word_d.vx  = vx_scaled;
			word_d.vy  = vy_scaled;
			word_d.ang = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= word_d;
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;

endmodule

@@ rtl/core/chp_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// chp_cordic_cell - one CORDIC vectoring micro-rotation
// Rotates toward the X axis by atan(2^-i) and hands the word to the next cell.
// ----------------------------------------------------------------------------
module chp_cordic_cell
	import chp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [STAGE_IDX_W-1:0] stage_idx,
	input  logic                   in_valid,
	input  chp_word_t              in_word,
	output logic                   out_valid,
	output chp_word_t              out_word
);

	logic signed [VEC_W-1:0] dx, dy;
	logic signed [ANG_W-1:0] step_ang;
	chp_word_t               word_d;
	logic                    valid_q;
	chp_word_t               word_q;

	always_comb begin
		dx       = in_word.vy >>> stage_idx;
		dy       = in_word.vx >>> stage_idx;
		step_ang = ATAN_TABLE[stage_idx];
		word_d   = in_word;
		// Y of zero counts as not positive: rotate counter-clockwise
		if (in_word.vy > 0) begin
			word_d.vx  = in_word.vx + dx;
			word_d.vy  = in_word.vy - dy;
			word_d.ang = in_word.ang + step_ang;
		end else begin
			word_d.vx  = in_word.vx - dx;
			word_d.vy  = in_word.vy + dy;
			word_d.ang = in_word.ang - step_ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

@@ rtl/core/chp_output_stage.sv @@
// ----------------------------------------------------------------------------
// chp_output_stage - angle wrap, rounding and result register
// Brings the angle into one turn, rounds to the heading grid, drives results.
// ----------------------------------------------------------------------------
module chp_output_stage
	import chp_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  chp_word_t                   in_word,
	output logic                        done,
	output logic signed [FIELD_W-1:0]   x_field,
	output logic signed [FIELD_W-1:0]   y_field,
	output logic signed [FIELD_W-1:0]   z_field,
	output logic [HEADING_W-1:0]        heading,
	output logic                        read_ok
);

	logic signed [ANG_W-1:0]    ang_pos;
	logic signed [ANG_W-1:0]    ang_rnd;
	logic [H_W-1:0]             h_raw;
	logic [H_W-1:0]             h_wrap;
	logic [HEADING_W-1:0]       heading_d;
	logic                       done_q;
	logic signed [FIELD_W-1:0]  x_field_q, y_field_q, z_field_q;
	logic [HEADING_W-1:0]       heading_q;
	logic                       read_ok_q;

	always_comb begin
		ang_pos   = (in_word.ang < 0) ? (in_word.ang + FULL_TURN_ANG) : in_word.ang;
		ang_rnd   = ang_pos + ROUND_HALF;
		h_raw     = ang_rnd[ANG_W-1:ROUND_SHIFT];
		// a heading that rounds up to a full turn wraps to zero
		h_wrap    = (h_raw >= TURN_HEADING) ? (h_raw - TURN_HEADING) : h_raw;
		heading_d = (in_word.ok && !in_word.zero_vec) ? HEADING_W'(h_wrap) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_field_q <= in_word.x_field;
		y_field_q <= in_word.y_field;
		z_field_q <= in_word.z_field;
		heading_q <= heading_d;
		read_ok_q <= in_word.ok;
	end

	assign done    = done_q;
	assign x_field = x_field_q;
	assign y_field = y_field_q;
	assign z_field = z_field_q;
	assign heading = heading_q;
	assign read_ok = read_ok_q;

endmodule

@@ rtl/core/compass_heading_from_raw_bytes.sv @@
// ----------------------------------------------------------------------------
// compass_heading_from_raw_bytes - magnetometer heading pipeline
// Six raw bytes in, signed X/Y/Z fields and an atan2 heading out.
// ----------------------------------------------------------------------------
// A word is taken on every clock edge where start is high; busy is always low,
// so a new read may be issued every cycle. Each word passes through one input
// register, one register per CORDIC cell, and the result register. The result
// is held on the ports for one cycle only, flagged by done; there is no way to
// hold it off, so capture it on that cycle. Heading is in 1/128 degree units,
// 0 up to 46079; a vector with X and Y both zero reads 0. A word with
// read_complete low comes back with read_ok low and every field zero.
// ----------------------------------------------------------------------------
module compass_heading_from_raw_bytes
	import chp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [7:0]                byte_0,
	input  logic [7:0]                byte_1,
	input  logic [7:0]                byte_2,
	input  logic [7:0]                byte_3,
	input  logic [7:0]                byte_4,
	input  logic [7:0]                byte_5,
	input  logic                      read_complete,
	output logic                      done,
	output logic signed [FIELD_W-1:0] x_field,
	output logic signed [FIELD_W-1:0] y_field,
	output logic signed [FIELD_W-1:0] z_field,
	output logic [HEADING_W-1:0]      heading,
	output logic                      read_ok
);

	// chain taps: entry 0 is the input register, entry k the output of cell k-1
	logic      chain_valid [RUN_STAGES+1];
	chp_word_t chain_word  [RUN_STAGES+1];

	// the pipeline never stalls: every cycle is open for a new word
	assign busy = 1'b0;

	// assemble bytes, fold X < 0 by a half turn
	chp_input_stage u_input (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (start),
		.byte_0        (byte_0),
		.byte_1        (byte_1),
		.byte_2        (byte_2),
		.byte_3        (byte_3),
		.byte_4        (byte_4),
		.byte_5        (byte_5),
		.read_complete (read_complete),
		.out_valid     (chain_valid[0]),
		.out_word      (chain_word[0])
	);

	// row of micro-rotation cells, cell i shifts by i and uses atan(2^-i)
	for (genvar i = 0; i < RUN_STAGES; i++) begin : g_cell
		chp_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_idx (STAGE_IDX_W'(i)),
			.in_valid  (chain_valid[i]),
			.in_word   (chain_word[i]),
			.out_valid (chain_valid[i+1]),
			.out_word  (chain_word[i+1])
		);
	end

	// wrap into one turn, round to the heading grid, present the result
	chp_output_stage u_output (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_valid[RUN_STAGES]),
		.in_word  (chain_word[RUN_STAGES]),
		.done     (done),
		.x_field  (x_field),
		.y_field  (y_field),
		.z_field  (z_field),
		.heading  (heading),
		.read_ok  (read_ok)
	);

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - compass heading pipeline check
// Drives raw magnetometer reads into the heading pipeline and compares every
// returned word with a bit-exact CORDIC heading predictor or a typed answer.
// A directed table covers the field extremes, the incomplete read, the zero
// vector, the negative-X half turn and the wrap at a full turn. A long run of
// random reads follows, sent in bursts with random gaps.
// ----------------------------------------------------------------------------
module testbench
	import chp_pkg::*;
();

	// one returned reading, in port order
	typedef struct packed {
		logic signed [FIELD_W-1:0] x_field;
		logic signed [FIELD_W-1:0] y_field;
		logic signed [FIELD_W-1:0] z_field;
		logic [HEADING_W-1:0]      heading;
		logic                      read_ok;
	} reading_t;

	// one row of the directed table: raw axis words plus an optional typed answer
	typedef struct packed {
		logic [15:0] x_raw;
		logic [15:0] y_raw;
		logic [15:0] z_raw;
		logic        complete;
		logic        typed;
		reading_t    typed_val;
	} stim_row_t;

	localparam int PERIOD_HALF   = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int PIPE_LATENCY  = RUN_STAGES + 2;
	localparam int RANDOM_WORDS  = 800;
	localparam int IDLE_LIMIT    = 4000;
	localparam int REPORT_LIMIT  = 10;
	localparam int ANGLE_FRAC    = 20;

	// atan(2^-i) in degrees at 2^-20 degree, rounded to nearest
	localparam longint ARCTAN_STEPS [24] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
		938658, 469357, 234682, 117342, 58671, 29335,
		14668, 7334, 3667, 1833, 917, 458,
		229, 115, 57, 29, 14, 7
	};

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [7:0]                byte_0;
	logic [7:0]                byte_1;
	logic [7:0]                byte_2;
	logic [7:0]                byte_3;
	logic [7:0]                byte_4;
	logic [7:0]                byte_5;
	logic                      read_complete;
	logic                      done;
	logic signed [FIELD_W-1:0] x_field;
	logic signed [FIELD_W-1:0] y_field;
	logic signed [FIELD_W-1:0] z_field;
	logic [HEADING_W-1:0]      heading;
	logic                      read_ok;

	// typed answer travels with the word so the scoreboard sees it at the accept edge
	logic     drv_typed;
	reading_t drv_typed_val;

	reading_t  pending_readings [$];
	stim_row_t stim_table [$];

	int fail_count;
	int mismatch_count;
	int words_sent;
	int readings_checked;
	int incomplete_sent;
	int zero_vec_sent;
	int idle_cycles;

	compass_heading_from_raw_bytes dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.byte_0        (byte_0),
		.byte_1        (byte_1),
		.byte_2        (byte_2),
		.byte_3        (byte_3),
		.byte_4        (byte_4),
		.byte_5        (byte_5),
		.read_complete (read_complete),
		.done          (done),
		.x_field       (x_field),
		.y_field       (y_field),
		.z_field       (z_field),
		.heading       (heading),
		.read_ok       (read_ok)
	);

	always begin
		#PERIOD_HALF clk = 1'b1;
		#PERIOD_HALF clk = 1'b0;
	end

	// Vectoring CORDIC on (x, y) scaled by 256; angle kept at 2^-20 degree.
	// A negative X starts half a turn around, a zero Y steers counter-clockwise.
	function automatic logic [HEADING_W-1:0] cordic_heading(
		input logic signed [15:0] xf,
		input logic signed [15:0] yf
	);
		longint vx;
		longint vy;
		longint ang;
		longint step_x;
		longint step_y;
		longint full_turn;
		longint hdg;
		int     i;
		full_turn = longint'(360) << ANGLE_FRAC;
		if (xf == 16'sd0 && yf == 16'sd0)
			return '0;
		vx = longint'(xf) * 256;
		vy = longint'(yf) * 256;
		ang = 0;
		if (vx < 0) begin
			vx = -vx;
			vy = -vy;
			ang = longint'(180) << ANGLE_FRAC;
		end
		for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			step_x = vy >>> i;
			step_y = vx >>> i;
			if (vy > 0) begin
				vx  = vx + step_x;
				vy  = vy - step_y;
				ang = ang + ARCTAN_STEPS[i];
			end else begin
				vx  = vx - step_x;
				vy  = vy + step_y;
				ang = ang - ARCTAN_STEPS[i];
			end
		end
		while (ang < 0)
			ang = ang + full_turn;
		while (ang >= full_turn)
			ang = ang - full_turn;
		// round half up to the heading grid, then fold a full turn back to zero
		hdg = (ang + (longint'(1) << (ANGLE_FRAC - 1 - HEADING_FRAC_BITS)))
			>> (ANGLE_FRAC - HEADING_FRAC_BITS);
		if (hdg >= (longint'(360) << HEADING_FRAC_BITS))
			hdg = hdg - (longint'(360) << HEADING_FRAC_BITS);
		return hdg[HEADING_W-1:0];
	endfunction

	function automatic reading_t predict_reading(
		input logic [15:0] xr,
		input logic [15:0] yr,
		input logic [15:0] zr,
		input logic        complete
	);
		reading_t r;
		r = '0;
		if (complete) begin
			r.x_field = xr;
			r.y_field = yr;
			r.z_field = zr;
			r.heading = cordic_heading(xr, yr);
			r.read_ok = 1'b1;
		end
		return r;
	endfunction

	function automatic stim_row_t mk_row(
		input logic [15:0] xr,
		input logic [15:0] yr,
		input logic [15:0] zr,
		input logic        complete
	);
		stim_row_t r;
		r = '0;
		r.x_raw    = xr;
		r.y_raw    = yr;
		r.z_raw    = zr;
		r.complete = complete;
		return r;
	endfunction

	// a row whose answer is obvious: failed read, or X and Y both zero
	function automatic stim_row_t mk_typed_row(
		input logic [15:0] xr,
		input logic [15:0] yr,
		input logic [15:0] zr,
		input logic        complete,
		input reading_t    val
	);
		stim_row_t r;
		r = mk_row(xr, yr, zr, complete);
		r.typed     = 1'b1;
		r.typed_val = val;
		return r;
	endfunction

	// bias toward the interesting corners: extremes, zero and tiny vectors
	function automatic logic [15:0] pick_axis();
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: v = 16'($urandom);
			6: v = 16'($urandom_range(0, 8)) - 16'd4;
			7: begin
				case ($urandom_range(0, 3))
					0: v = 16'h7FFF;
					1: v = 16'h8000;
					2: v = 16'hFFFF;
					default: v = 16'h0001;
				endcase
			end
			8: v = 16'h0000;
			default: v = 16'($urandom_range(0, 600)) - 16'd300;
		endcase
		return v;
	endfunction

	// Present one word and hold it until the edge that takes it.
	task automatic send_word(input stim_row_t r);
		start         <= 1'b1;
		byte_0        <= r.x_raw[15:8];
		byte_1        <= r.x_raw[7:0];
		byte_2        <= r.y_raw[15:8];
		byte_3        <= r.y_raw[7:0];
		byte_4        <= r.z_raw[15:8];
		byte_5        <= r.z_raw[7:0];
		read_complete <= r.complete;
		drv_typed     <= r.typed;
		drv_typed_val <= r.typed_val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drop start for a gap; a zero gap keeps the burst going.
	task automatic idle_gap(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drop start and hold off until every word in flight has come back.
	task automatic drain_pipe();
		start <= 1'b0;
		@(posedge clk);
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	// Scoreboard: check the returned word first, then log the word taken on
	// this edge. Both look at values from before the edge.
	always @(posedge clk) begin : scoreboard
		reading_t got;
		reading_t want;
		logic     moved;
		moved = 1'b0;
		if (arst_n) begin
			if (done) begin
				moved = 1'b1;
				got = '{x_field, y_field, z_field, heading, read_ok};
				if (pending_readings.size() == 0) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("[%0t] stray word: x=%0d y=%0d z=%0d hdg=%0d ok=%0b",
							$realtime, got.x_field, got.y_field, got.z_field,
							got.heading, got.read_ok);
				end else begin
					want = pending_readings.pop_front();
					readings_checked++;
					if (got.x_field !== want.x_field || got.y_field !== want.y_field ||
						got.z_field !== want.z_field || got.heading !== want.heading ||
						got.read_ok !== want.read_ok) begin
						fail_count++;
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display("[%0t] mismatch: want x=%0d y=%0d z=%0d hdg=%0d ok=%0b",
								$realtime, want.x_field, want.y_field, want.z_field,
								want.heading, want.read_ok);
							$display("    got x=%0d y=%0d z=%0d hdg=%0d ok=%0b",
								got.x_field, got.y_field, got.z_field, got.heading,
								got.read_ok);
						end
					end
				end
			end
			if (start && !busy) begin
				moved = 1'b1;
				words_sent++;
				if (!read_complete)
					incomplete_sent++;
				else if ({byte_0, byte_1, byte_2, byte_3} == 32'h0)
					zero_vec_sent++;
				if (drv_typed)
					pending_readings.push_back(drv_typed_val);
				else
					pending_readings.push_back(predict_reading({byte_0, byte_1},
						{byte_2, byte_3}, {byte_4, byte_5}, read_complete));
			end
			// watchdog: count edges with no traffic either way
			if (moved)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[%0t] watchdog: no traffic for %0d cycles, %0d words pending",
					$realtime, IDLE_LIMIT, pending_readings.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		stim_row_t r;
		int        burst_left;
		int        n;
		fail_count       = 0;
		mismatch_count   = 0;
		words_sent       = 0;
		readings_checked = 0;
		incomplete_sent  = 0;
		zero_vec_sent    = 0;
		idle_cycles      = 0;
		clk              = 1'b0;
		arst_n        <= 1'b0;
		start         <= 1'b0;
		byte_0        <= '0;
		byte_1        <= '0;
		byte_2        <= '0;
		byte_3        <= '0;
		byte_4        <= '0;
		byte_5        <= '0;
		read_complete <= 1'b0;
		drv_typed     <= 1'b0;
		drv_typed_val <= '0;

		// Directed table. Typed rows: failed reads and the zero X/Y vector.
		stim_table.push_back(mk_typed_row(16'h0000, 16'h0000, 16'h0000, 1'b1, '0 | 1'b1));
		stim_table.push_back(mk_typed_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0));
		stim_table.push_back(mk_typed_row(16'h1234, 16'h8000, 16'h7FFF, 1'b0, '0));
		stim_table.push_back(mk_typed_row(16'h0000, 16'h0000, 16'h7FFF, 1'b1,
			'{16'sd0, 16'sd0, 16'sh7FFF, 16'd0, 1'b1}));
		stim_table.push_back(mk_typed_row(16'h0000, 16'h0000, 16'h8000, 1'b1,
			'{16'sd0, 16'sd0, 16'sh8000, 16'd0, 1'b1}));
		// axis extremes and the four quadrant boundaries
		stim_table.push_back(mk_row(16'h7FFF, 16'h0000, 16'h0000, 1'b1));
		stim_table.push_back(mk_row(16'h8000, 16'h0000, 16'hFFFF, 1'b1));
		stim_table.push_back(mk_row(16'h0000, 16'h7FFF, 16'h0001, 1'b1));
		stim_table.push_back(mk_row(16'h0000, 16'h8000, 16'h8000, 1'b1));
		stim_table.push_back(mk_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
		stim_table.push_back(mk_row(16'h8000, 16'h8000, 16'h8000, 1'b1));
		stim_table.push_back(mk_row(16'h8000, 16'h7FFF, 16'h0000, 1'b1));
		stim_table.push_back(mk_row(16'h7FFF, 16'h8000, 16'h00FF, 1'b1));
		// negative X: half-turn start, with Y exactly zero and just either side
		stim_table.push_back(mk_row(16'hFFFF, 16'h0000, 16'hFF00, 1'b1));
		stim_table.push_back(mk_row(16'hFFFF, 16'h0001, 16'h0000, 1'b1));
		stim_table.push_back(mk_row(16'h8000, 16'hFFFF, 16'h0000, 1'b1));
		stim_table.push_back(mk_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		// just below a full turn: rounds up to 360 and folds back to zero
		stim_table.push_back(mk_row(16'h7FFF, 16'hFFFF, 16'h0000, 1'b1));
		stim_table.push_back(mk_row(16'h4000, 16'hFFFF, 16'h0000, 1'b1));
		// tiny vectors and single-bit patterns
		stim_table.push_back(mk_row(16'h0001, 16'h0000, 16'h0000, 1'b1));
		stim_table.push_back(mk_row(16'h0001, 16'h0001, 16'h5555, 1'b1));
		stim_table.push_back(mk_row(16'h00FF, 16'hFF00, 16'hAAAA, 1'b1));
		stim_table.push_back(mk_row(16'h5555, 16'hAAAA, 16'h0F0F, 1'b1));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// walk the table back to back, no gaps
		foreach (stim_table[i])
			send_word(stim_table[i]);

		// let the pipe run dry once before the random part
		drain_pipe();

		// Random reads in bursts; a gap of zero joins two bursts.
		burst_left = 0;
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 2) != 0)
					idle_gap($urandom_range(1, 12));
			end
			if (n == RANDOM_WORDS / 2)
				drain_pipe();
			r = mk_row(pick_axis(), pick_axis(), pick_axis(),
				($urandom_range(0, 9) != 0));
			send_word(r);
			burst_left--;
		end
		start <= 1'b0;

		// wait out the pipe, then a margin for any stray words
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		fail_count += pending_readings.size();

		$display("Sent %0d reads (%0d incomplete, %0d with zero X/Y), checked %0d words.",
			words_sent, incomplete_sent, zero_vec_sent, readings_checked);
		$display("Mismatches or stray words: %0d.", mismatch_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ compass_heading_from_raw_bytes.f @@
rtl/core/chp_pkg.sv
rtl/core/chp_input_stage.sv
rtl/core/chp_cordic_cell.sv
rtl/core/chp_output_stage.sv
rtl/core/compass_heading_from_raw_bytes.sv
dv/testbench.sv
